[rtl/lsma_pkg.sv]
package lsma_pkg;

	localparam int ANGLE_BINS = 360;
	localparam int BIN_W      = $clog2(ANGLE_BINS);
	localparam int DIST_W     = 16;
	localparam int ANGLE_W    = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [DIST_W-1:0] THRESHOLD_RST = DIST_W'(300);
	localparam logic [7:0]        WINDOW_RST    = 8'd15;
	localparam logic [7:0]        CONE_RST      = 8'd30;

	localparam logic [BIN_W-1:0]  LAST_BIN      = BIN_W'(ANGLE_BINS - 1);
	localparam logic [BIN_W-1:0]  HALF_BINS     = BIN_W'(ANGLE_BINS / 2);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_WINDOW    = 2'd1,
		CFG_CONE      = 2'd2
	} cfg_idx_t;

	// which map address the read port takes
	typedef enum logic [1:0] {
		RD_CUR = 2'd0,
		RD_LO  = 2'd1,
		RD_HI  = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic    item_load;
		logic    mem_clr_wr;
		logic    mem_item_wr;
		logic    idx_clr;
		logic    idx_inc;
		rd_sel_t rd_sel;
		logic    cap_v;
		logic    cap_lo;
		logic    acc_clr;
		logic    eval;
		logic    load_out;
	} lsma_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic item_done;
	} lsma_status_t;

endpackage

[rtl/lsma_datapath.sv]
module lsma_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lsma_pkg::lsma_cmd_t                    cmd,
	output lsma_pkg::lsma_status_t                 status,
	input  logic signed [lsma_pkg::ANGLE_W-1:0]    angle_q4,
	input  logic        [lsma_pkg::DIST_W-1:0]     distance,
	input  logic                                   scan_done,
	input  logic                                   cfg_wr_en,
	input  logic        [lsma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [lsma_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                   nearest_found,
	output logic        [lsma_pkg::BIN_W-1:0]      nearest_angle,
	output logic                                   corner_found,
	output logic        [lsma_pkg::BIN_W-1:0]      corner_angle,
	output logic                                   path_blocked
);
	import lsma_pkg::*;

	logic [DIST_W-1:0] map_mem [ANGLE_BINS];
	logic [DIST_W-1:0] rdata_q;

	logic [DIST_W-1:0] threshold_q;
	logic [7:0]        window_q;
	logic [7:0]        cone_q;

	logic [BIN_W-1:0]  bin_q;
	logic [DIST_W-1:0] dist_q;
	logic              done_q;
	logic [BIN_W-1:0]  idx_q;

	logic [DIST_W-1:0] v_q;
	logic [DIST_W-1:0] lo_q;
	logic              near_ok_q;
	logic [DIST_W-1:0] near_val_q;
	logic [BIN_W-1:0]  near_idx_q;
	logic              corner_ok_q;
	logic [DIST_W-1:0] corner_val_q;
	logic [BIN_W-1:0]  corner_idx_q;
	logic              blocked_q;

	// angle to bin: round by +8/16, truncate toward zero, wrap into 0..359
	logic signed [ANGLE_W:0]   a_rnd;
	logic signed [ANGLE_W:0]   a_adj;
	logic signed [11:0]        deg;
	logic signed [11:0]        deg_t;
	logic signed [11:0]        deg_w;
	logic        [BIN_W-1:0]   bin_d;

	always_comb begin
		a_rnd = {angle_q4[ANGLE_W-1], angle_q4} + (ANGLE_W+1)'(8);
		a_adj = a_rnd[ANGLE_W] ? a_rnd + (ANGLE_W+1)'(15) : a_rnd;
		deg   = 12'(a_adj >>> 4);
		deg_t = deg[11] ? deg + 12'sd360 : deg;
		if (deg_t[11]) begin
			deg_w = deg_t + 12'sd360;
		end else if (deg_t >= 12'sd360) begin
			deg_w = deg_t - 12'sd360;
		end else begin
			deg_w = deg_t;
		end
		bin_d = deg_w[BIN_W-1:0];
	end

	// neighbor addresses with wraparound
	logic [BIN_W:0]    lo_sum;
	logic [BIN_W:0]    hi_sum;
	logic [BIN_W-1:0]  lo_addr;
	logic [BIN_W-1:0]  hi_addr;
	logic [BIN_W-1:0]  raddr;

	always_comb begin
		lo_sum  = {1'b0, idx_q} + (BIN_W+1)'(ANGLE_BINS) - {2'b00, window_q};
		hi_sum  = {1'b0, idx_q} + {2'b00, window_q};
		lo_addr = (lo_sum >= (BIN_W+1)'(ANGLE_BINS)) ?
			BIN_W'(lo_sum - (BIN_W+1)'(ANGLE_BINS)) : lo_sum[BIN_W-1:0];
		hi_addr = (hi_sum >= (BIN_W+1)'(ANGLE_BINS)) ?
			BIN_W'(hi_sum - (BIN_W+1)'(ANGLE_BINS)) : hi_sum[BIN_W-1:0];
		case (cmd.rd_sel)
			RD_CUR:  raddr = idx_q;
			RD_LO:   raddr = lo_addr;
			RD_HI:   raddr = hi_addr;
			default: raddr = idx_q;
		endcase
	end

	// map memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.mem_clr_wr) begin
			map_mem[idx_q] <= '0;
		end else if (cmd.mem_item_wr && (dist_q != '0)) begin
			map_mem[bin_q] <= dist_q;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= map_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			window_q    <= WINDOW_RST;
			cone_q      <= CONE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data;
				CFG_WINDOW:    window_q    <= cfg_data[7:0];
				CFG_CONE:      cone_q      <= cfg_data[7:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + BIN_W'(1);
			end
			if (cmd.item_load) begin
				done_q <= scan_done;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			bin_q  <= bin_d;
			dist_q <= distance;
		end
		if (cmd.cap_v) begin
			v_q <= rdata_q;
		end
		if (cmd.cap_lo) begin
			lo_q <= rdata_q;
		end
	end

	// per-bin evaluation; read data holds the high neighbor here
	logic [BIN_W-1:0] circ;
	logic             near_upd;
	logic             corner_upd;
	logic             block_hit;

	always_comb begin
		circ       = (idx_q <= HALF_BINS) ? idx_q : BIN_W'(ANGLE_BINS) - idx_q;
		near_upd   = (v_q != '0) && (!near_ok_q || (v_q < near_val_q));
		corner_upd = (v_q != '0) && (lo_q != '0) && (rdata_q != '0) &&
			(v_q > lo_q) && (v_q > rdata_q) &&
			(!corner_ok_q || (v_q < corner_val_q));
		block_hit  = (v_q != '0) && (circ <= {1'b0, cone_q}) && (v_q < threshold_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_ok_q   <= 1'b0;
			corner_ok_q <= 1'b0;
			blocked_q   <= 1'b0;
			near_idx_q  <= '0;
			corner_idx_q <= '0;
		end else if (cmd.acc_clr) begin
			near_ok_q    <= 1'b0;
			corner_ok_q  <= 1'b0;
			blocked_q    <= 1'b0;
			near_idx_q   <= '0;
			corner_idx_q <= '0;
		end else if (cmd.eval) begin
			if (near_upd) begin
				near_ok_q  <= 1'b1;
				near_idx_q <= idx_q;
			end
			if (corner_upd) begin
				corner_ok_q  <= 1'b1;
				corner_idx_q <= idx_q;
			end
			if (block_hit) begin
				blocked_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval && near_upd) begin
			near_val_q <= v_q;
		end
		if (cmd.eval && corner_upd) begin
			corner_val_q <= v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			nearest_found <= near_ok_q;
			nearest_angle <= near_idx_q;
			corner_found  <= corner_ok_q;
			corner_angle  <= corner_idx_q;
			path_blocked  <= blocked_q;
		end
	end

	assign status.idx_last  = (idx_q == LAST_BIN);
	assign status.item_done = done_q;

endmodule

[rtl/lsma_ctrl.sv]
module lsma_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  lsma_pkg::lsma_status_t status,
	output lsma_pkg::lsma_cmd_t    cmd
);
	import lsma_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_STORE,
		ST_RD_V,
		ST_RD_LO,
		ST_RD_HI,
		ST_EVAL,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RD_CUR;
		case (state_q)
			ST_CLEAR: begin
				cmd.mem_clr_wr = 1'b1;
				cmd.idx_inc    = 1'b1;
				cmd.idx_clr    = status.idx_last;
			end
			ST_IDLE: begin
				cmd.item_load = in_valid;
			end
			ST_STORE: begin
				cmd.mem_item_wr = 1'b1;
				cmd.idx_clr     = 1'b1;
				cmd.acc_clr     = 1'b1;
			end
			ST_RD_V: begin
				cmd.rd_sel = RD_CUR;
			end
			ST_RD_LO: begin
				cmd.rd_sel = RD_LO;
				cmd.cap_v  = 1'b1;
			end
			ST_RD_HI: begin
				cmd.rd_sel = RD_HI;
				cmd.cap_lo = 1'b1;
			end
			ST_EVAL: begin
				cmd.eval    = 1'b1;
				cmd.idx_inc = !status.idx_last;
			end
			ST_HOLD: begin
				cmd.load_out = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			out_valid <= 1'b0;
		end else begin
			if ((state_q == ST_HOLD) && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (status.idx_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					state_q <= status.item_done ? ST_RD_V : ST_IDLE;
				end
				ST_RD_V:  state_q <= ST_RD_LO;
				ST_RD_LO: state_q <= ST_RD_HI;
				ST_RD_HI: state_q <= ST_EVAL;
				ST_EVAL: begin
					state_q <= status.idx_last ? ST_HOLD : ST_RD_V;
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/lidar_scan_map_analyzer.sv]
// A point without end of scan is stored in the cycle after it is taken; in_stall
//   is high for that cycle, so the next point waits until the store is done.
// A point that ends a scan starts a walk over every bin through the map's single
//   read port: read the bin, its low and high neighbors, then evaluate it; the result
//   is loaded when the output is free. Reset: the map is swept to zero bin by bin
//   with in_stall high; the registers return to 300, 15 and 30.
module lidar_scan_map_analyzer (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [lsma_pkg::ANGLE_W-1:0]    angle_q4,
	input  logic        [lsma_pkg::DIST_W-1:0]     distance,
	input  logic                                   scan_done,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   nearest_found,
	output logic        [lsma_pkg::BIN_W-1:0]      nearest_angle,
	output logic                                   corner_found,
	output logic        [lsma_pkg::BIN_W-1:0]      corner_angle,
	output logic                                   path_blocked,
	input  logic                                   cfg_wr_en,
	input  logic        [lsma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [lsma_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lsma_pkg::*;

	lsma_cmd_t    cmd;
	lsma_status_t status;

	lsma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lsma_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.angle_q4      (angle_q4),
		.distance      (distance),
		.scan_done     (scan_done),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.nearest_found (nearest_found),
		.nearest_angle (nearest_angle),
		.corner_found  (corner_found),
		.corner_angle  (corner_angle),
		.path_blocked  (path_blocked)
	);

endmodule

[rtl/lsma_checker.sv]
module lsma_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              nearest_found,
	input logic [lsma_pkg::BIN_W-1:0]        nearest_angle,
	input logic                              corner_found,
	input logic [lsma_pkg::BIN_W-1:0]        corner_angle
);
	import lsma_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(nearest_angle) &&
			$stable(corner_angle))
		else $error("stalled result changed or dropped");

	// every corner bin is nonzero, so a corner implies a nearest bin
	a_corner_near: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && corner_found |-> nearest_found)
		else $error("corner reported on empty map");

	a_empty_angle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !nearest_found |-> nearest_angle == '0)
		else $error("nearest angle nonzero with no reading");

	// the store cycle after any taken item blocks the next one
	a_store_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken during store");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (nearest_angle <= LAST_BIN) && (corner_angle <= LAST_BIN))
		else $error("angle out of range");

endmodule

bind lidar_scan_map_analyzer lsma_checker u_lsma_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.nearest_found (nearest_found),
	.nearest_angle (nearest_angle),
	.corner_found  (corner_found),
	.corner_angle  (corner_angle)
);
